>>> design/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that cons holds in the cycle where ante holds.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/chbd_pkg.sv
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, constants and character helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package chbd_pkg;

  localparam int SIZE_BITS_DEF = 32;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    hex_decode = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      hex_decode = {1'b1, d[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      hex_decode = {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      hex_decode = {1'b1, d[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

>>> design/chbd_parse.sv
// ----------------------------------------------------------------------------
// chbd_parse
// Framing parser: updates parser state for one byte and forms its results.
// ----------------------------------------------------------------------------
`default_nettype none

module chbd_parse #(
  parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_fire,
  input  logic [7:0]      item_data,
  input  logic            item_eoi,
  output chbd_pkg::push_t push
);

  typedef enum logic [2:0] {
    M_LINE,
    M_TRAIL,
    M_EXT,
    M_DATA,
    M_END_CR_OR_LF,
    M_END_LF
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [SIZE_BITS-1:0] left_r, left_nxt;
  logic                 seen_r, seen_nxt;
  logic                 fin_r, fin_nxt;

  logic       st_vld;
  logic [1:0] st_code;
  logic       emit_data;
  logic [4:0] hx;
  logic       sp;
  chbd_pkg::result_t data_res, stat_res;

  always_comb begin
    mode_nxt  = mode_r;
    size_nxt  = size_r;
    left_nxt  = left_r;
    seen_nxt  = seen_r;
    fin_nxt   = fin_r;
    st_vld    = 1'b0;
    st_code   = chbd_pkg::ST_OK;
    emit_data = 1'b0;
    hx        = chbd_pkg::hex_decode(item_data);
    sp        = chbd_pkg::is_space(item_data);
    case (mode_r)
      M_LINE: begin
        if (hx[4]) begin
          if (size_r[SIZE_BITS-1 -: 4] != 4'd0) begin
            st_vld  = 1'b1;
            st_code = chbd_pkg::ST_BAD;
          end else begin
            size_nxt = {size_r[SIZE_BITS-5:0], hx[3:0]};
            seen_nxt = 1'b1;
          end
        end else if (!seen_r) begin
          if (!sp) begin
            st_vld  = 1'b1;
            st_code = chbd_pkg::ST_BAD;
          end
        end else if (item_data == chbd_pkg::CH_LF) begin
          if (size_r == '0) begin
            st_vld  = 1'b1;
            st_code = chbd_pkg::ST_OK;
          end else begin
            left_nxt = size_r;
            mode_nxt = M_DATA;
          end
        end else if (item_data == chbd_pkg::CH_SEMI) begin
          mode_nxt = M_EXT;
        end else if (sp) begin
          mode_nxt = M_TRAIL;
        end else begin
          st_vld  = 1'b1;
          st_code = chbd_pkg::ST_BAD;
        end
      end
      M_TRAIL, M_EXT: begin
        if (item_data == chbd_pkg::CH_LF) begin
          if (size_r == '0) begin
            st_vld  = 1'b1;
            st_code = chbd_pkg::ST_OK;
          end else begin
            left_nxt = size_r;
            mode_nxt = M_DATA;
          end
        end else if (mode_r == M_TRAIL && !sp) begin
          st_vld  = 1'b1;
          st_code = chbd_pkg::ST_BAD;
        end
      end
      M_DATA: begin
        emit_data = 1'b1;
        left_nxt  = left_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};
        if (left_r == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
          mode_nxt = M_END_CR_OR_LF;
        end
      end
      M_END_CR_OR_LF, M_END_LF: begin
        if (item_data == chbd_pkg::CH_CR && mode_r == M_END_CR_OR_LF) begin
          mode_nxt = M_END_LF;
        end else if (item_data == chbd_pkg::CH_LF) begin
          mode_nxt = M_LINE;
          size_nxt = '0;
          seen_nxt = 1'b0;
        end else begin
          st_vld  = 1'b1;
          st_code = chbd_pkg::ST_BAD;
        end
      end
      default: begin
        st_vld  = 1'b1;
        st_code = chbd_pkg::ST_BAD;
      end
    endcase
    if (!st_vld && item_eoi) begin
      st_vld  = 1'b1;
      st_code = chbd_pkg::ST_EARLY;
    end
    if (st_vld) begin
      fin_nxt = 1'b1;
    end
  end

  always_comb begin
    data_res = '{out_byte: item_data, is_status: 1'b0,
                 status: chbd_pkg::ST_OK, last: !st_vld};
    stat_res = '{out_byte: 8'h00, is_status: 1'b1, status: st_code, last: 1'b1};
    push.cnt = 2'd0;
    push.r0  = data_res;
    push.r1  = stat_res;
    if (item_fire && !fin_r) begin
      if (emit_data && st_vld) begin
        push.cnt = 2'd2;
      end else if (emit_data) begin
        push.cnt = 2'd1;
      end else if (st_vld) begin
        push.cnt = 2'd1;
        push.r0  = stat_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_LINE;
      size_r <= '0;
      left_r <= '0;
      seen_r <= 1'b0;
      fin_r  <= 1'b0;
    end else if (item_fire && !fin_r) begin
      mode_r <= mode_nxt;
      size_r <= size_nxt;
      left_r <= left_nxt;
      seen_r <= seen_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/chbd_fifo.sv
// ----------------------------------------------------------------------------
// chbd_fifo
// Result queue: takes up to two results per cycle, gives one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module chbd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chbd_pkg::push_t       push,
  input  logic                  pop,
  output chbd_pkg::result_t     head,
  output logic                  not_empty,
  output logic [chbd_pkg::QAW:0] level
);

  chbd_pkg::result_t mem [chbd_pkg::QDEPTH];

  logic [chbd_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [chbd_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic [chbd_pkg::QAW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + {{(chbd_pkg::QAW-1){1'b0}}, 1'b1};
  assign cnt_nxt   = cnt_r + {{(chbd_pkg::QAW-1){1'b0}}, push.cnt}
                   - {{chbd_pkg::QAW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + (chbd_pkg::QAW)'(push.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + {{(chbd_pkg::QAW-1){1'b0}}, 1'b1};
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign level     = cnt_r;

endmodule

`default_nettype wire

>>> design/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes HTTP chunked framing; passes chunk data and one final status.
// ----------------------------------------------------------------------------
// Flow: a transferred byte is held in an input register and is parsed when
//   the result queue has room; its results are written to the queue.
// Throughput: one byte per cycle while the result queue has room; a byte that
//   yields two results (data plus early-end status) takes two queue entries.
// Reset: synchronous active-low rst_n clears parser state and empties queue.
`default_nettype none
`include "assert_macros.svh"

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_status,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic [7:0] data_r;
  logic       eoi_r;
  logic       full_r, full_nxt;
  logic       room;
  logic       consume;
  logic       pop;

  chbd_pkg::push_t        push;
  chbd_pkg::result_t      head;
  logic                   not_empty;
  logic [chbd_pkg::QAW:0] level;

  assign room     = (level <= (chbd_pkg::QAW+1)'(chbd_pkg::QDEPTH - 2));
  assign consume  = full_r && room;
  assign in_stall = full_r && !room;
  assign full_nxt = (in_valid && !in_stall) ? 1'b1 : (consume ? 1'b0 : full_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data_byte;
      eoi_r  <= in_end_of_input;
    end
  end

  chbd_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_fire(consume),
    .item_data(data_r),
    .item_eoi (eoi_r),
    .push     (push)
  );

  assign pop = not_empty && !out_stall;

  chbd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .not_empty(not_empty),
    .level    (level)
  );

  assign out_valid     = not_empty;
  assign out_byte      = head.out_byte;
  assign out_is_status = head.is_status;
  assign out_status    = head.status;
  assign out_last      = head.last;

  `ASSERT_ALWAYS(a_level_bound, level <= (chbd_pkg::QAW+1)'(chbd_pkg::QDEPTH))
  `ASSERT_IMPLIES(a_status_last, out_valid && out_is_status, out_last && out_byte == 8'h00)
  `ASSERT_IMPLIES(a_data_ok, out_valid && !out_is_status, out_status == chbd_pkg::ST_OK)
  `ASSERT_NEXT(a_stall_holds_item, in_stall, full_r)

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Runs one long chunked body through http_chunked_body_decoder: a few
// hand-built chunks, then random chunks with random line layout and data,
// closed by one randomly chosen ending (zero size, framing fault, overflow
// or an early end mark), followed by bytes that must be ignored. A
// scoreboard class tracks the parser state of every accepted byte and
// checks each result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SIZE_W = chbd_pkg::SIZE_BITS_DEF;

  typedef enum logic [3:0] {
    PM_LINE, PM_TRAIL, PM_EXT, PM_DATA, PM_CRLF, PM_LF
  } parse_mode_e;

  typedef enum int {
    END_ZERO, END_EMPTY, END_SIGN, END_HEXPFX, END_AFTER_WS,
    END_OVERFLOW, END_BAD_TERM, END_TRUNC, END_HUGE
  } body_end_e;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
  } body_byte_t;

  class decode_scoreboard;
    parse_mode_e       mode;
    logic [SIZE_W-1:0] size_acc;
    logic [SIZE_W-1:0] bytes_left;
    bit                seen_digit;
    bit                finished;
    chbd_pkg::result_t due_q[$];
    int                n_inputs;
    int                n_errors;

    function new();
      start_line();
      bytes_left = '0;
      finished   = 1'b0;
      n_inputs   = 0;
      n_errors   = 0;
    endfunction

    function void start_line();
      mode       = PM_LINE;
      size_acc   = '0;
      seen_digit = 1'b0;
    endfunction

    function bit blank(logic [7:0] c);
      return c == chbd_pkg::CH_SP || c == chbd_pkg::CH_TAB || c == chbd_pkg::CH_CR;
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    // Returns 1 when the line closes the body (zero size).
    function bit close_line();
      if (size_acc == '0) return 1'b1;
      bytes_left = size_acc;
      mode       = PM_DATA;
      return 1'b0;
    endfunction

    function void note_input(logic [7:0] c, logic eoi);
      chbd_pkg::result_t pay;
      chbd_pkg::result_t fin;
      bit                has_pay;
      bit                has_st;
      logic [1:0]        st;
      int                h;
      n_inputs++;
      if (finished) return;
      has_pay = 1'b0;
      has_st  = 1'b0;
      st      = chbd_pkg::ST_OK;
      pay     = '0;
      h       = hex_value(c);
      case (mode)
        PM_LINE: begin
          if (h >= 0) begin
            if (size_acc[SIZE_W-1 -: 4] != 4'd0) begin
              has_st = 1'b1;
              st     = chbd_pkg::ST_BAD;
            end else begin
              size_acc   = {size_acc[SIZE_W-5:0], h[3:0]};
              seen_digit = 1'b1;
            end
          end else if (!seen_digit) begin
            if (!blank(c)) begin
              has_st = 1'b1;
              st     = chbd_pkg::ST_BAD;
            end
          end else if (c == chbd_pkg::CH_LF) begin
            has_st = close_line();
          end else if (c == chbd_pkg::CH_SEMI) begin
            mode = PM_EXT;
          end else if (blank(c)) begin
            mode = PM_TRAIL;
          end else begin
            has_st = 1'b1;
            st     = chbd_pkg::ST_BAD;
          end
        end
        PM_TRAIL: begin
          if (c == chbd_pkg::CH_LF) begin
            has_st = close_line();
          end else if (!blank(c)) begin
            has_st = 1'b1;
            st     = chbd_pkg::ST_BAD;
          end
        end
        PM_EXT: begin
          if (c == chbd_pkg::CH_LF) has_st = close_line();
        end
        PM_DATA: begin
          has_pay      = 1'b1;
          pay.out_byte = c;
          bytes_left   = bytes_left - {{(SIZE_W-1){1'b0}}, 1'b1};
          if (bytes_left == '0) mode = PM_CRLF;
        end
        PM_CRLF: begin
          if (c == chbd_pkg::CH_CR) begin
            mode = PM_LF;
          end else if (c == chbd_pkg::CH_LF) begin
            start_line();
          end else begin
            has_st = 1'b1;
            st     = chbd_pkg::ST_BAD;
          end
        end
        PM_LF: begin
          if (c == chbd_pkg::CH_LF) begin
            start_line();
          end else begin
            has_st = 1'b1;
            st     = chbd_pkg::ST_BAD;
          end
        end
        default: begin
          has_st = 1'b1;
          st     = chbd_pkg::ST_BAD;
        end
      endcase
      if (!has_st && eoi) begin
        has_st = 1'b1;
        st     = chbd_pkg::ST_EARLY;
      end
      if (has_pay) begin
        pay.last = !has_st;
        due_q.insert(due_q.size(), pay);
      end
      if (has_st) begin
        finished      = 1'b1;
        fin           = '0;
        fin.is_status = 1'b1;
        fin.status    = st;
        fin.last      = 1'b1;
        due_q.insert(due_q.size(), fin);
      end
    endfunction

    function void field_check(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
        n_errors++;
      end
    endfunction

    function void check_result(logic [7:0] b, logic is_st, logic [1:0] st, logic lst);
      chbd_pkg::result_t e;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %0h %s %0b/%0d last %0b",
                 $time, b, "status", is_st, st, lst);
        n_errors++;
        return;
      end
      e = due_q.pop_front();
      field_check("out_byte", int'(e.out_byte), int'(b));
      field_check("is_status", int'(e.is_status), int'(is_st));
      field_check("status", int'(e.status), int'(st));
      field_check("last", int'(e.last), int'(lst));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_end_of_input;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_is_status;
  logic [1:0] out_status;
  logic       out_last;

  decode_scoreboard sb = new();
  body_byte_t       body_q[$];

  http_chunked_body_decoder #(
    .SIZE_BITS(SIZE_W)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_input(in_end_of_input),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_status  (out_is_status),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("** http_chunked_body_decoder: FAILED **");
    $finish;
  end

  function automatic void put(logic [7:0] b);
    body_byte_t t;
    t.b   = b;
    t.eoi = 1'b0;
    body_q.insert(body_q.size(), t);
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 2))
      0:       return chbd_pkg::CH_SP;
      1:       return chbd_pkg::CH_TAB;
      default: return chbd_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] not_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == chbd_pkg::CH_LF) ? chbd_pkg::CH_SEMI : b;
  endfunction

  function automatic void put_hex(logic [31:0] v);
    int top;
    top = 7;
    while (top > 0 && v[top*4 +: 4] == 4'd0) top--;
    for (int i = top; i >= 0; i--) put(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void put_size_line(logic [31:0] sz);
    int n;
    n = $urandom_range(0, 2);
    repeat (n) put(pick_ws());
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 1);
    repeat (n) put("0");
    put_hex(sz);
    case ($urandom_range(0, 3))
      1: begin
        n = $urandom_range(1, 2);
        repeat (n) put($urandom_range(0, 1) ? chbd_pkg::CH_SP : chbd_pkg::CH_TAB);
        if ($urandom_range(0, 1)) put(chbd_pkg::CH_CR);
      end
      2: begin
        put(chbd_pkg::CH_SEMI);
        n = $urandom_range(0, 5);
        repeat (n) put(not_lf());
      end
      3: put(chbd_pkg::CH_CR);
      default: ;
    endcase
    put(chbd_pkg::CH_LF);
  endfunction

  function automatic void put_chunk_body(int unsigned sz);
    repeat (sz) put(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_chunk(int unsigned sz);
    put_size_line(sz);
    put_chunk_body(sz);
    if ($urandom_range(0, 1)) put(chbd_pkg::CH_CR);
    put(chbd_pkg::CH_LF);
  endfunction

  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  function automatic void build_body();
    body_end_e   kind;
    logic [7:0]  b;
    int          start;
    int          cut;
    int          n;
    int unsigned sz;
    // leading whitespace, long leading zeros, trailing blanks, LF-only end
    put(chbd_pkg::CH_TAB); put(chbd_pkg::CH_SP); put(chbd_pkg::CH_CR);
    repeat (9) put("0");
    put("3"); put(chbd_pkg::CH_SP); put(chbd_pkg::CH_CR); put(chbd_pkg::CH_LF);
    put(8'h00); put(8'hFF); put(chbd_pkg::CH_LF);
    put(chbd_pkg::CH_LF);
    // extension with odd bytes, CRLF end
    put("1"); put(chbd_pkg::CH_SEMI); put(8'hFF); put("a");
    put(chbd_pkg::CH_CR); put(chbd_pkg::CH_LF);
    put(8'h80); put(chbd_pkg::CH_CR); put(chbd_pkg::CH_LF);

    while (body_q.size() < 1650) put_chunk(pick_size());

    kind = body_end_e'($urandom_range(0, int'(END_HUGE)));
    case (kind)
      END_ZERO: put_size_line(32'd0);
      END_EMPTY: begin
        if ($urandom_range(0, 1)) put(pick_ws());
        put($urandom_range(0, 1) ? chbd_pkg::CH_LF : chbd_pkg::CH_SEMI);
      end
      END_SIGN: begin
        put($urandom_range(0, 1) ? "+" : "-");
      end
      END_HEXPFX: begin
        put("0");
        put($urandom_range(0, 1) ? "x" : "X");
      end
      END_AFTER_WS: begin
        put(hex_char(4'($urandom_range(1, 15))));
        put(pick_ws());
        put($urandom_range(0, 1) ? chbd_pkg::CH_SEMI : hex_char(4'($urandom_range(0, 15))));
      end
      END_OVERFLOW: begin
        n = $urandom_range(0, 3);
        repeat (n) put("0");
        put(hex_char(4'($urandom_range(1, 15))));
        repeat (8) put(hex_char(4'($urandom_range(0, 15))));
      end
      END_BAD_TERM: begin
        sz = $urandom_range(1, 6);
        put_size_line(sz);
        put_chunk_body(sz);
        if ($urandom_range(0, 1)) begin
          put(chbd_pkg::CH_CR);
          b = not_lf();
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == chbd_pkg::CH_CR || b == chbd_pkg::CH_LF);
        end
        put(b);
      end
      default: ;
    endcase
    if (kind == END_TRUNC) begin
      start = body_q.size();
      put_chunk($urandom_range(1, 12));
      cut = $urandom_range(start, body_q.size() - 1);
      while (body_q.size() > cut + 1) void'(body_q.pop_back());
      body_q[cut].eoi = 1'b1;
    end else if (kind == END_HUGE) begin
      repeat (8) put(hex_char(4'hF));
      put(chbd_pkg::CH_LF);
      put_chunk_body($urandom_range(1, 5));
      body_q[body_q.size()-1].eoi = 1'b1;
    end else begin
      body_q[body_q.size()-1].eoi = 1'($urandom_range(0, 1));
    end
    // bytes after the final status
    n = $urandom_range(1, 4);
    repeat (n) begin
      put(8'($urandom_range(0, 255)));
      body_q[body_q.size()-1].eoi = 1'($urandom_range(0, 1));
    end
    body_q[body_q.size()-1].eoi = 1'b1;
  endfunction

  function automatic bit sender_rests(int k);
    if (k >= 700 && k < 1000) return 1'b0;
    return $urandom_range(0, 99) < 31;
  endfunction

  task automatic drive_body();
    int k;
    k = 0;
    while (k < body_q.size()) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        sb.note_input(in_data_byte, in_end_of_input);
        k++;
      end
      if (!(in_valid && in_stall)) begin
        if (k < body_q.size() && !sender_rests(k)) begin
          in_valid        <= 1'b1;
          in_data_byte    <= body_q[k].b;
          in_end_of_input <= body_q[k].eoi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  endtask

  initial begin
    int hold_left;
    bit pressed;
    hold_left = 0;
    pressed   = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_byte, out_is_status, out_status, out_last);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!pressed && sb.n_inputs >= 300) begin
        pressed   = 1'b1;
        hold_left = 399;
        out_stall <= 1'b1;
      end else if (sb.n_inputs >= 700 && sb.n_inputs < 1000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 31);
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_data_byte    <= 8'h00;
    in_end_of_input <= 1'b0;
    build_body();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    drive_body();
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.due_q.size());
      sb.n_errors++;
    end
    if (sb.n_errors == 0) begin
      $display("** http_chunked_body_decoder: PASSED **");
    end else begin
      $display("** http_chunked_body_decoder: FAILED **");
    end
    $finish;
  end

endmodule

>>> http_chunked_body_decoder.f
+incdir+design
design/chbd_pkg.sv
design/chbd_parse.sv
design/chbd_fifo.sv
design/http_chunked_body_decoder.sv
tb/testbench.sv
